// ----- design/pidrl_pkg.sv -----
`default_nettype none
// ============================================================================
// pidrl_pkg
// Shared types, register indices and saturation helpers for the ramp-limited
// PID controller.
// ============================================================================
package pidrl_pkg;

    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_RAMP_LIMIT = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [30:0]        output_limit;
        logic [30:0]        ramp_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] prop;
        logic signed [31:0] integ_step;
        logic signed [32:0] deriv;
    } terms_t;

    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7fffffff;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                     input logic [30:0] lim);
        logic signed [31:0] pos;
        logic signed [31:0] r;
        pos = {1'b0, lim};
        if (v > pos)
            r = pos;
        else if (v < -pos)
            r = -pos;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/pid_controller_ramp_limited.sv -----
`default_nettype none
// ============================================================================
// pid_controller_ramp_limited
// Discrete PID controller, trapezoidal integral, output limit and ramp limit.
// ============================================================================
// Timing: an accepted error word is registered in the term stage, then in the
//   output register, from which its drive word can be taken.
// Throughput: one word per cycle while the sink does not stall; products in the
//   first stage, integral and clamp recurrence in the second, term register between.
// Reset: clears gains, limits, integral, previous output and previous error.
module pid_controller_ramp_limited
    import pidrl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   write_enable,
    input  wire logic [CFG_INDEX_W-1:0] write_index,
    input  wire logic [CFG_DATA_W-1:0]  write_data,
    input  wire logic signed [15:0]     error_sample,
    input  wire logic                   error_sample_valid,
    output logic                        error_sample_ready,
    output logic signed [31:0]          drive_value,
    output logic                        drive_value_valid,
    input  wire logic                   drive_value_ready
);

    cfg_t   cfg;
    terms_t terms;
    logic   t_valid;
    logic   t_ready;

    pidrl_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .cfg          (cfg)
    );

    pidrl_term_stage u_term (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .error_sample (error_sample),
        .in_valid     (error_sample_valid),
        .in_ready     (error_sample_ready),
        .terms        (terms),
        .t_valid      (t_valid),
        .t_ready      (t_ready)
    );

    pidrl_acc_stage u_acc (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .terms             (terms),
        .t_valid           (t_valid),
        .t_ready           (t_ready),
        .drive_value       (drive_value),
        .drive_value_valid (drive_value_valid),
        .drive_value_ready (drive_value_ready)
    );

endmodule
`default_nettype wire

// ----- design/pidrl_cfg_regs.sv -----
`default_nettype none
// ============================================================================
// pidrl_cfg_regs
// Configuration register file: gains, output limit and ramp limit.
// ============================================================================
module pidrl_cfg_regs
    import pidrl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   write_enable,
    input  wire logic [CFG_INDEX_W-1:0] write_index,
    input  wire logic [CFG_DATA_W-1:0]  write_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (write_index)
                REG_GAIN_P:     cfg_next.gain_p       = write_data[15:0];
                REG_GAIN_I:     cfg_next.gain_i       = write_data[15:0];
                REG_GAIN_D:     cfg_next.gain_d       = write_data[15:0];
                REG_OUT_LIMIT:  cfg_next.output_limit = write_data;
                REG_RAMP_LIMIT: cfg_next.ramp_limit   = write_data;
                default:        cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- design/pidrl_term_stage.sv -----
`default_nettype none
// ============================================================================
// pidrl_term_stage
// First stage: the three gain products from the incoming error word and the
// previous error, registered.
// ============================================================================
module pidrl_term_stage
    import pidrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic signed [15:0] error_sample,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output terms_t                  terms,
    output logic                    t_valid,
    input  wire logic               t_ready
);

    logic               t_valid_reg;
    logic               t_valid_next;
    terms_t             terms_reg;
    terms_t             terms_next;
    logic signed [15:0] last_error_reg;
    logic signed [16:0] err_sum;
    logic signed [16:0] err_diff;
    logic signed [32:0] integ_prod;
    logic               accept;

    assign in_ready = !t_valid_reg || t_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        err_sum          = 17'(error_sample) + 17'(last_error_reg);
        err_diff         = 17'(error_sample) - 17'(last_error_reg);
        integ_prod       = 33'(cfg.gain_i) * 33'(err_sum);
        terms_next.prop  = 32'(cfg.gain_p) * 32'(error_sample);
        // floor of half: arithmetic shift
        terms_next.integ_step = integ_prod[32:1];
        terms_next.deriv = 33'(cfg.gain_d) * 33'(err_diff);
        if (accept)
            t_valid_next = 1'b1;
        else if (t_ready)
            t_valid_next = 1'b0;
        else
            t_valid_next = t_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg    <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            t_valid_reg <= t_valid_next;
            if (accept)
                last_error_reg <= error_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            terms_reg <= terms_next;
    end

    assign terms   = terms_reg;
    assign t_valid = t_valid_reg;

endmodule
`default_nettype wire

// ----- design/pidrl_acc_stage.sv -----
`default_nettype none
// ============================================================================
// pidrl_acc_stage
// Second stage: integral update, output sum, limit and ramp clamps; the
// output register doubles as the previous-output state.
// ============================================================================
module pidrl_acc_stage
    import pidrl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire terms_t       terms,
    input  wire logic         t_valid,
    output logic              t_ready,
    output logic signed [31:0] drive_value,
    output logic              drive_value_valid,
    input  wire logic         drive_value_ready
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] integral_acc_reg;
    logic signed [31:0] integral_acc_next;
    logic signed [31:0] last_output_reg;
    logic signed [31:0] last_output_next;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [35:0] out_sum;
    logic signed [31:0] out_sat;
    logic signed [31:0] out_lim;
    logic signed [32:0] rate;
    logic signed [32:0] ramp33;
    logic signed [32:0] ramp_up;
    logic signed [32:0] ramp_down;
    logic               load;

    assign t_ready = !out_valid_reg || drive_value_ready;
    assign load    = t_valid && t_ready;

    always_comb
    begin
        integ_sum = 33'(integral_acc_reg) + 33'(terms.integ_step);
        integ_sat = sat32(36'(integ_sum));
        if (cfg.output_limit != '0)
            integral_acc_next = clamp_mag(integ_sat, cfg.output_limit);
        else
            integral_acc_next = integ_sat;

        out_sum = 36'(terms.prop) + 36'(integral_acc_next) + 36'(terms.deriv);
        out_sat = sat32(out_sum);
        if (cfg.output_limit != '0)
            out_lim = clamp_mag(out_sat, cfg.output_limit);
        else
            out_lim = out_sat;

        ramp33    = {2'b00, cfg.ramp_limit};
        rate      = 33'(out_lim) - 33'(last_output_reg);
        ramp_up   = 33'(last_output_reg) + ramp33;
        ramp_down = 33'(last_output_reg) - ramp33;
        if (cfg.ramp_limit != '0 && rate > ramp33)
            last_output_next = sat32(36'(ramp_up));
        else if (cfg.ramp_limit != '0 && rate < -ramp33)
            last_output_next = sat32(36'(ramp_down));
        else
            last_output_next = out_lim;

        if (load)
            out_valid_next = 1'b1;
        else if (drive_value_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            integral_acc_reg <= '0;
            last_output_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                integral_acc_reg <= integral_acc_next;
                last_output_reg  <= last_output_next;
            end
        end
    end

    assign drive_value       = last_output_reg;
    assign drive_value_valid = out_valid_reg;

    a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded word missing from output register");

    a_integral_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load && cfg.output_limit != '0 |=>
            (integral_acc_reg <= $signed({1'b0, $past(cfg.output_limit)})) &&
            (integral_acc_reg >= -$signed({1'b0, $past(cfg.output_limit)})))
        else $error("stored integral outside limit");

    a_ramp_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && cfg.ramp_limit != '0 |=>
            ((33'(last_output_reg) - 33'($past(last_output_reg)))
                <= $signed({2'b00, $past(cfg.ramp_limit)})) &&
            ((33'(last_output_reg) - 33'($past(last_output_reg)))
                >= -$signed({2'b00, $past(cfg.ramp_limit)})))
        else $error("output step exceeds ramp limit");

endmodule
`default_nettype wire

// ----- test/pid_drive_check_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pid_drive_check_pkg
// Scoreboard for the ramp-limited PID controller. It keeps its own gains,
// limits and controller state, predicts each drive word and checks the words
// that come out.
// ============================================================================
package pid_drive_check_pkg;

    import pidrl_pkg::*;

    localparam longint DRIVE_MAX = 64'sh7fff_ffff;
    localparam longint DRIVE_MIN = -64'sh8000_0000;

    class drive_scoreboard;

        logic signed [15:0] kp = '0;
        logic signed [15:0] ki = '0;
        logic signed [15:0] kd = '0;
        logic [30:0]        out_lim = '0;
        logic [30:0]        ramp_lim = '0;

        logic signed [31:0] integ_acc = '0;
        logic signed [31:0] prev_drive = '0;
        logic signed [15:0] prev_err = '0;

        logic signed [31:0] expected_drive[$];
        int unsigned        fail_count = 0;

        function longint clip32(longint v);
            if (v > DRIVE_MAX)
                return DRIVE_MAX;
            if (v < DRIVE_MIN)
                return DRIVE_MIN;
            return v;
        endfunction

        function longint clamp_to(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:     kp = data[15:0];
                REG_GAIN_I:     ki = data[15:0];
                REG_GAIN_D:     kd = data[15:0];
                REG_OUT_LIMIT:  out_lim = data;
                REG_RAMP_LIMIT: ramp_lim = data;
                default:        ;
            endcase
        endfunction

        function void take_error(logic signed [15:0] e);
            longint lim;
            longint ramp;
            longint prop;
            longint integ;
            longint deriv;
            longint drive;
            longint delta;
            lim   = longint'(out_lim);
            ramp  = longint'(ramp_lim);
            prop  = longint'(kp) * longint'(e);
            // trapezoid step, arithmetic shift floors toward minus infinity
            integ = clip32(longint'(integ_acc) +
                           ((longint'(ki) * (longint'(e) + longint'(prev_err))) >>> 1));
            if (lim != 0)
                integ = clamp_to(integ, lim);
            deriv = longint'(kd) * (longint'(e) - longint'(prev_err));
            drive = clip32(prop + integ + deriv);
            if (lim != 0)
                drive = clamp_to(drive, lim);
            if (ramp != 0)
            begin
                delta = drive - longint'(prev_drive);
                if (delta > ramp)
                    drive = clip32(longint'(prev_drive) + ramp);
                else if (delta < -ramp)
                    drive = clip32(longint'(prev_drive) - ramp);
            end
            integ_acc  = 32'(integ);
            prev_drive = 32'(drive);
            prev_err   = e;
            expected_drive.push_back(32'(drive));
        endfunction

        function void check_drive(logic signed [31:0] got);
            logic signed [31:0] want;
            if (expected_drive.size() == 0)
            begin
                $error("drive_value: expected no word, got %0d", got);
                fail_count++;
            end
            else
            begin
                want = expected_drive.pop_front();
                if (got !== want)
                begin
                    $error("drive_value: expected %0d, got %0d", want, got);
                    fail_count++;
                end
            end
        endfunction

    endclass

endpackage

// ----- test/tb_pid_controller_ramp_limited.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_pid_controller_ramp_limited
// Drives error words through the PID controller under several gain, limit
// and ramp settings and checks every drive word against the scoreboard.
// A short directed run covers saturation and clamp extremes, then random
// phases with bursty input and a stalling sink, one long sink hold-off.
// ============================================================================
module tb_pid_controller_ramp_limited;

    import pidrl_pkg::*;
    import pid_drive_check_pkg::*;

    localparam int DRIVE_LATENCY   = 2;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_AFTER      = 330;
    localparam int HOLD_CYCLES     = 150;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] write_index = '0;
    logic [CFG_DATA_W-1:0]  write_data = '0;
    logic signed [15:0]     error_sample = '0;
    logic                   error_sample_valid = 1'b0;
    logic                   error_sample_ready;
    logic signed [31:0]     drive_value;
    logic                   drive_value_valid;
    logic                   drive_value_ready = 1'b0;

    drive_scoreboard sb = new;

    pid_controller_ramp_limited dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .write_enable       (write_enable),
        .write_index        (write_index),
        .write_data         (write_data),
        .error_sample       (error_sample),
        .error_sample_valid (error_sample_valid),
        .error_sample_ready (error_sample_ready),
        .drive_value        (drive_value),
        .drive_value_valid  (drive_value_valid),
        .drive_value_ready  (drive_value_ready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic cfg_t make_cfg(logic signed [15:0] p, logic signed [15:0] i,
                                      logic signed [15:0] d, logic [30:0] lim,
                                      logic [30:0] ramp);
        cfg_t c;
        c.gain_p       = p;
        c.gain_i       = i;
        c.gain_d       = d;
        c.output_limit = lim;
        c.ramp_limit   = ramp;
        return c;
    endfunction

    function automatic logic signed [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 1024)) - 512);
            2:       return 16'(int'($urandom_range(0, 64)) - 32);
            default:
                case ($urandom_range(0, 2))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    default: return 16'sh0000;
                endcase
        endcase
    endfunction

    function automatic logic [30:0] pick_magnitude();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 31'($urandom);
            2:       return 31'($urandom_range(1, 1 << 24));
            3:       return 31'h7fff_ffff;
            default: return 31'($urandom_range(1, 256));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_error();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 16'(int'($urandom_range(0, 4096)) - 2048);
        if (r < 17)
            return 16'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    // all five registers, gains with junk above bit 15, then one stray index
    task automatic load_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals[5];
        vals[REG_GAIN_P]     = {15'($urandom), c.gain_p};
        vals[REG_GAIN_I]     = {15'($urandom), c.gain_i};
        vals[REG_GAIN_D]     = {15'($urandom), c.gain_d};
        vals[REG_OUT_LIMIT]  = c.output_limit;
        vals[REG_RAMP_LIMIT] = c.ramp_limit;
        for (int i = 0; i <= REG_RAMP_LIMIT; i++)
        begin
            write_enable <= 1'b1;
            write_index  <= CFG_INDEX_W'(i);
            write_data   <= vals[i];
            sb.write_reg(CFG_INDEX_W'(i), vals[i]);
            @(posedge clk);
        end
        write_index <= CFG_INDEX_W'($urandom_range(REG_RAMP_LIMIT + 1, (1 << CFG_INDEX_W) - 1));
        write_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.expected_drive.size() != 0)
            @(posedge clk);
        repeat (DRIVE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic offer_error(input logic signed [15:0] w);
        error_sample_valid <= 1'b1;
        error_sample       <= w;
        do
            @(posedge clk);
        while (!error_sample_ready);
        sb.take_error(w);
    endtask

    task automatic offer_list(input logic signed [15:0] words[$]);
        foreach (words[k])
            offer_error(words[k]);
        error_sample_valid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin : word_source
        bit          gappy;
        int unsigned burst_left;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, all gains zero
        offer_list('{16'sh7fff, 16'sh8000, 16'sh0000});

        // unclamped, saturating sums and odd negative integral steps
        load_config(make_cfg(16'sh7fff, 16'sh7fff, 16'sh8000, '0, '0));
        offer_list('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                     16'shffff, 16'sh0000, 16'sh0001, 16'shffff});

        // widest limit, narrowest ramp
        load_config(make_cfg(16'sh0100, 16'sh0080, 16'sh0040, 31'h7fff_ffff, 31'h1));
        offer_list('{16'sh0064, -16'sh0064, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000});

        // narrowest limit, widest ramp
        load_config(make_cfg(16'sh8000, 16'sh8000, 16'sh7fff, 31'h1, 31'h7fff_ffff));
        offer_list('{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh0000, 16'sh7fff});

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_config(make_cfg(pick_gain(), pick_gain(), pick_gain(),
                                 pick_magnitude(), pick_magnitude()));
            gappy      = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                offer_error(pick_error());
                burst_left--;
                if (gappy && burst_left == 0)
                begin
                    error_sample_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst_left = $urandom_range(1, 40);
                end
            end
            error_sample_valid <= 1'b0;
            wait_idle();
        end

        if (sb.fail_count == 0 && sb.expected_drive.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : drive_sink
        int unsigned taken;
        int unsigned hold;
        int unsigned style;
        int unsigned style_left;
        bit          held_off;
        taken      = 0;
        hold       = 0;
        style      = 0;
        style_left = 0;
        held_off   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (drive_value_valid && drive_value_ready)
            begin
                sb.check_drive(drive_value);
                taken++;
            end
            // one long hold-off so the pipeline backs up into the input
            if (!held_off && taken >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                hold     = HOLD_CYCLES;
            end
            if (hold != 0)
            begin
                hold--;
                drive_value_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                case (style)
                    0:       drive_value_ready <= 1'b1;
                    1:       drive_value_ready <= 1'($urandom_range(0, 1));
                    2:       drive_value_ready <= ($urandom_range(0, 3) == 0);
                    default: drive_value_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

endmodule
